// File: rtl/lruc_pkg.sv
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types, widths and codes for the keyed LRU cache with fetch tracking.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int GEN_W    = 16;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 4;

    localparam int DEF_CACHE_ENTRIES = 16;
    localparam int DEF_PENDING_SLOTS = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_REQUEST = 3'd0,
        MODE_LOOKUP  = 3'd1,
        MODE_FILL    = 3'd2,
        MODE_STOP    = 3'd3,
        MODE_CLEAR   = 3'd4,
        MODE_ATTACH  = 3'd5
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_IGNORED     = 4'd0,
        ST_READY       = 4'd1,
        ST_ISSUED      = 4'd2,
        ST_HIT         = 4'd3,
        ST_MISS        = 4'd4,
        ST_STALE       = 4'd5,
        ST_TABLE_FULL  = 4'd6,
        ST_OUTSTANDING = 4'd7,
        ST_CTRL_DONE   = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_FETCH,
        FSM_EXEC
    } t_fsm;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic fetch;
        logic exec;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
    } t_dp_sts;

endpackage

// File: rtl/lru_cache_with_inflight_tracking.sv
// ----------------------------------------------------------------------------
// lru_cache_with_inflight_tracking
// Keyed handle cache with true LRU replacement, outstanding-fetch table and
// generation epoch.
// ----------------------------------------------------------------------------
// Sequence: after the accepting edge the block scans both tables, then
//   drains, fetches the target entry and executes; o_valid is registered.
// The scan reads one entry and one fetch slot per cycle; a new word is not
//   accepted until the block returns to idle.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset: synchronous, active low; empties both tables, zeroes the epoch.
module lru_cache_with_inflight_tracking #(
    parameter int CACHE_ENTRIES = lruc_pkg::DEF_CACHE_ENTRIES,
    parameter int PENDING_SLOTS = lruc_pkg::DEF_PENDING_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lruc_pkg::MODE_W-1:0]   i_mode,
    input  logic [lruc_pkg::KEY_W-1:0]    i_key,
    input  logic [lruc_pkg::HANDLE_W-1:0] i_handle,
    input  logic [lruc_pkg::GEN_W-1:0]    i_fill_generation,
    output logic                          o_valid,
    output logic [lruc_pkg::STAT_W-1:0]   o_status,
    output logic [lruc_pkg::KEY_W-1:0]    o_result_key,
    output logic [lruc_pkg::HANDLE_W-1:0] o_result_handle,
    output logic [lruc_pkg::GEN_W-1:0]    o_issue_generation,
    output logic                          o_evicted,
    output logic [lruc_pkg::KEY_W-1:0]    o_evicted_key
);
    import lruc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequence each word: capture, scan, drain, fetch target, execute
    lruc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // hold tables and produce the result word
    lruc_datapath #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .PENDING_SLOTS (PENDING_SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_mode             (i_mode),
        .i_key              (i_key),
        .i_handle           (i_handle),
        .i_fill_generation  (i_fill_generation),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_result_key       (o_result_key),
        .o_result_handle    (o_result_handle),
        .o_issue_generation (o_issue_generation),
        .o_evicted          (o_evicted),
        .o_evicted_key      (o_evicted_key)
    );

endmodule

// File: rtl/lruc_ctrl.sv
// ----------------------------------------------------------------------------
// lruc_ctrl
// Sequencer: capture, scan tables, drain, fetch target entry, execute.
// ----------------------------------------------------------------------------
module lruc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lruc_pkg::t_dp_sts i_sts,
    output lruc_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import lruc_pkg::*;

    t_fsm r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            FSM_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = FSM_DRAIN;
                end
            end
            FSM_DRAIN: begin
                n_state = FSM_FETCH;
            end
            FSM_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = FSM_EXEC;
            end
            FSM_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = FSM_IDLE;
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lruc_datapath.sv
// ----------------------------------------------------------------------------
// lruc_datapath
// Entry and fetch tables, scan compare, LRU age update and result registers.
// ----------------------------------------------------------------------------
module lruc_datapath #(
    parameter int CACHE_ENTRIES = lruc_pkg::DEF_CACHE_ENTRIES,
    parameter int PENDING_SLOTS = lruc_pkg::DEF_PENDING_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lruc_pkg::t_dp_cmd             i_cmd,
    output lruc_pkg::t_dp_sts             o_sts,
    input  logic [lruc_pkg::MODE_W-1:0]   i_mode,
    input  logic [lruc_pkg::KEY_W-1:0]    i_key,
    input  logic [lruc_pkg::HANDLE_W-1:0] i_handle,
    input  logic [lruc_pkg::GEN_W-1:0]    i_fill_generation,
    output logic                          o_valid,
    output logic [lruc_pkg::STAT_W-1:0]   o_status,
    output logic [lruc_pkg::KEY_W-1:0]    o_result_key,
    output logic [lruc_pkg::HANDLE_W-1:0] o_result_handle,
    output logic [lruc_pkg::GEN_W-1:0]    o_issue_generation,
    output logic                          o_evicted,
    output logic [lruc_pkg::KEY_W-1:0]    o_evicted_key
);
    import lruc_pkg::*;

    localparam int SCAN_LEN = (CACHE_ENTRIES > PENDING_SLOTS) ? CACHE_ENTRIES : PENDING_SLOTS;
    localparam int CW = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;
    localparam int EW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    // storage
    logic [KEY_W-1:0]    key_mem  [CACHE_ENTRIES];
    logic [HANDLE_W-1:0] hdl_mem  [CACHE_ENTRIES];
    logic [KEY_W-1:0]    pkey_mem [PENDING_SLOTS];

    logic [CACHE_ENTRIES-1:0] r_valid, n_valid;
    logic [EW-1:0]            r_age [CACHE_ENTRIES];
    logic [EW-1:0]            n_age [CACHE_ENTRIES];
    logic [PENDING_SLOTS-1:0] r_pvalid, n_pvalid;
    logic [GEN_W-1:0]         r_epoch, n_epoch;
    logic                     r_stopping, n_stopping;
    logic                     r_attached, n_attached;

    // captured word
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    logic [GEN_W-1:0]    r_gen, n_gen;

    // scan
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx_d;
    logic          r_cmp_vld;
    logic          r_ehit, n_ehit;
    logic [EW-1:0] r_eidx, n_eidx;
    logic          r_efree_f, n_efree_f;
    logic [EW-1:0] r_efree, n_efree;
    logic [EW-1:0] r_victim, n_victim;
    logic [EW-1:0] r_best, n_best;
    logic          r_phit, n_phit;
    logic [PW-1:0] r_pidx, n_pidx;
    logic          r_pfree_f, n_pfree_f;
    logic [PW-1:0] r_pfree, n_pfree;

    // memory read data
    logic [KEY_W-1:0]    r_key_q;
    logic [HANDLE_W-1:0] r_hdl_q;
    logic [KEY_W-1:0]    r_pkey_q;
    logic [EW-1:0]       rd_eaddr;
    logic [PW-1:0]       rd_paddr;

    // writes
    logic          key_we, hdl_we, pkey_we;
    logic [EW-1:0] wr_eaddr;

    // results
    logic                r_out_vld;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [KEY_W-1:0]    r_rkey, n_rkey;
    logic [HANDLE_W-1:0] r_rhdl, n_rhdl;
    logic [GEN_W-1:0]    r_igen, n_igen;
    logic                r_ev, n_ev;
    logic [KEY_W-1:0]    r_evkey, n_evkey;

    logic          ent_in, pend_in;
    logic [EW-1:0] se;
    logic [PW-1:0] sp;
    logic [EW-1:0] touch_age;

    assign o_sts.scan_last = (r_cnt == CW'(SCAN_LEN - 1));

    assign rd_eaddr = i_cmd.fetch ? (r_ehit ? r_eidx : r_victim) : r_cnt[EW-1:0];
    assign rd_paddr = r_cnt[PW-1:0];

    assign ent_in  = ({1'b0, r_idx_d} < (CW + 1)'(CACHE_ENTRIES));
    assign pend_in = ({1'b0, r_idx_d} < (CW + 1)'(PENDING_SLOTS));
    assign se      = r_idx_d[EW-1:0];
    assign sp      = r_idx_d[PW-1:0];
    assign touch_age = r_age[r_eidx];

    always_ff @(posedge i_clk) begin
        r_key_q  <= key_mem[rd_eaddr];
        r_hdl_q  <= hdl_mem[rd_eaddr];
        r_pkey_q <= pkey_mem[rd_paddr];
        if (key_we) begin
            key_mem[wr_eaddr] <= r_key;
        end
        if (hdl_we) begin
            hdl_mem[wr_eaddr] <= r_handle;
        end
        if (pkey_we) begin
            pkey_mem[r_pfree] <= r_key;
        end
    end

    always_comb begin
        n_valid    = r_valid;
        n_age      = r_age;
        n_pvalid   = r_pvalid;
        n_epoch    = r_epoch;
        n_stopping = r_stopping;
        n_attached = r_attached;
        n_mode     = r_mode;
        n_key      = r_key;
        n_handle   = r_handle;
        n_gen      = r_gen;
        n_cnt      = r_cnt;
        n_ehit     = r_ehit;
        n_eidx     = r_eidx;
        n_efree_f  = r_efree_f;
        n_efree    = r_efree;
        n_victim   = r_victim;
        n_best     = r_best;
        n_phit     = r_phit;
        n_pidx     = r_pidx;
        n_pfree_f  = r_pfree_f;
        n_pfree    = r_pfree;
        n_status   = r_status;
        n_rkey     = r_rkey;
        n_rhdl     = r_rhdl;
        n_igen     = r_igen;
        n_ev       = r_ev;
        n_evkey    = r_evkey;
        key_we     = 1'b0;
        hdl_we     = 1'b0;
        pkey_we    = 1'b0;
        wr_eaddr   = r_eidx;

        if (i_cmd.load) begin
            n_mode    = i_mode;
            n_key     = i_key;
            n_handle  = i_handle;
            n_gen     = i_fill_generation;
            n_cnt     = '0;
            n_ehit    = 1'b0;
            n_efree_f = 1'b0;
            n_victim  = '0;
            n_best    = '0;
            n_phit    = 1'b0;
            n_pfree_f = 1'b0;
        end
        if (i_cmd.scan) begin
            n_cnt = r_cnt + CW'(1);
        end

        // compare one entry and one slot per cycle
        if (r_cmp_vld) begin
            if (ent_in) begin
                if (r_valid[se] && (r_key_q == r_key) && !r_ehit) begin
                    n_ehit = 1'b1;
                    n_eidx = se;
                end
                if (!r_valid[se] && !r_efree_f) begin
                    n_efree_f = 1'b1;
                    n_efree   = se;
                end
                if (r_valid[se] && (r_age[se] > r_best)) begin
                    n_best   = r_age[se];
                    n_victim = se;
                end
            end
            if (pend_in) begin
                if (r_pvalid[sp] && (r_pkey_q == r_key) && !r_phit) begin
                    n_phit = 1'b1;
                    n_pidx = sp;
                end
                if (!r_pvalid[sp] && !r_pfree_f) begin
                    n_pfree_f = 1'b1;
                    n_pfree   = sp;
                end
            end
        end

        if (i_cmd.exec) begin
            n_status = ST_IGNORED;
            n_rkey   = '0;
            n_rhdl   = '0;
            n_igen   = '0;
            n_ev     = 1'b0;
            n_evkey  = '0;
            case (r_mode)
                MODE_REQUEST: begin
                    n_rkey = r_key;
                    if (!r_stopping && r_attached) begin
                        if (r_ehit) begin
                            n_status = ST_READY;
                        end else if (r_phit) begin
                            n_status = ST_OUTSTANDING;
                        end else if (r_pfree_f) begin
                            n_pvalid[r_pfree] = 1'b1;
                            pkey_we  = 1'b1;
                            n_status = ST_ISSUED;
                            n_igen   = r_epoch;
                        end else begin
                            n_status = ST_TABLE_FULL;
                        end
                    end
                end
                MODE_LOOKUP: begin
                    n_rkey = r_key;
                    if (r_ehit) begin
                        for (int i = 0; i < CACHE_ENTRIES; i++) begin
                            if (r_valid[i] && (EW'(i) != r_eidx) && (r_age[i] < touch_age)) begin
                                n_age[i] = r_age[i] + EW'(1);
                            end
                        end
                        n_age[r_eidx] = '0;
                        n_status = ST_HIT;
                        n_rhdl   = r_hdl_q;
                    end else begin
                        n_status = ST_MISS;
                    end
                end
                MODE_FILL: begin
                    n_rkey = r_key;
                    if (r_phit) begin
                        n_pvalid[r_pidx] = 1'b0;
                    end
                    if (r_gen != r_epoch) begin
                        n_status = ST_STALE;
                    end else begin
                        n_status = ST_READY;
                        hdl_we   = 1'b1;
                        if (r_ehit) begin
                            wr_eaddr = r_eidx;
                            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                                if (r_valid[i] && (EW'(i) != r_eidx) &&
                                    (r_age[i] < touch_age)) begin
                                    n_age[i] = r_age[i] + EW'(1);
                                end
                            end
                            n_age[r_eidx] = '0;
                        end else begin
                            key_we   = 1'b1;
                            wr_eaddr = r_efree_f ? r_efree : r_victim;
                            n_ev     = !r_efree_f;
                            n_evkey  = r_efree_f ? '0 : r_key_q;
                            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                                if (r_valid[i] && !(!r_efree_f && (EW'(i) == r_victim))) begin
                                    n_age[i] = r_age[i] + EW'(1);
                                end
                            end
                            n_valid[wr_eaddr] = 1'b1;
                            n_age[wr_eaddr]   = '0;
                        end
                    end
                end
                MODE_STOP: begin
                    n_stopping = 1'b1;
                    n_epoch    = r_epoch + GEN_W'(1);
                    n_status   = ST_CTRL_DONE;
                end
                MODE_CLEAR: begin
                    n_valid    = '0;
                    for (int i = 0; i < CACHE_ENTRIES; i++) begin
                        n_age[i] = '0;
                    end
                    n_pvalid   = '0;
                    n_attached = 1'b0;
                    n_stopping = 1'b0;
                    n_status   = ST_CTRL_DONE;
                end
                MODE_ATTACH: begin
                    n_attached = 1'b1;
                    n_status   = ST_CTRL_DONE;
                end
                default: begin
                    n_status = ST_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                r_age[i] <= '0;
            end
            r_pvalid   <= '0;
            r_epoch    <= '0;
            r_stopping <= 1'b0;
            r_attached <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_valid    <= n_valid;
            r_age      <= n_age;
            r_pvalid   <= n_pvalid;
            r_epoch    <= n_epoch;
            r_stopping <= n_stopping;
            r_attached <= n_attached;
            r_cmp_vld  <= i_cmd.scan;
            r_out_vld  <= i_cmd.exec;
            r_cnt      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_d   <= r_cnt;
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_handle  <= n_handle;
        r_gen     <= n_gen;
        r_ehit    <= n_ehit;
        r_eidx    <= n_eidx;
        r_efree_f <= n_efree_f;
        r_efree   <= n_efree;
        r_victim  <= n_victim;
        r_best    <= n_best;
        r_phit    <= n_phit;
        r_pidx    <= n_pidx;
        r_pfree_f <= n_pfree_f;
        r_pfree   <= n_pfree;
        r_status  <= n_status;
        r_rkey    <= n_rkey;
        r_rhdl    <= n_rhdl;
        r_igen    <= n_igen;
        r_ev      <= n_ev;
        r_evkey   <= n_evkey;
    end

    assign o_valid            = r_out_vld;
    assign o_status           = r_status;
    assign o_result_key       = r_rkey;
    assign o_result_handle    = r_rhdl;
    assign o_issue_generation = r_igen;
    assign o_evicted          = r_ev;
    assign o_evicted_key      = r_evkey;

endmodule
